// ===== rtl/segy_pkg.sv =====
// Shared types, codes and helpers for the sample-to-IEEE converter.
`timescale 1ns / 1ps
package segy_pkg;

    localparam logic [2:0] FMT_IBM   = 3'd0;
    localparam logic [2:0] FMT_INT32 = 3'd1;
    localparam logic [2:0] FMT_INT16 = 3'd2;
    localparam logic [2:0] FMT_IEEE  = 3'd3;
    localparam logic [2:0] FMT_INT8  = 3'd4;

    localparam logic [0:0] REG_FORMAT = 1'd0;
    localparam logic [0:0] REG_SWAP   = 1'd1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_ZEROMANT  = 2'd3;

    localparam logic [31:0] MAX_FINITE = 32'h7f7fffff;
    localparam int          QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,
        KIND_IBM  = 2'd1,
        KIND_INT  = 2'd2,
        KIND_PASS = 2'd3
    } kind_t;

    // Classified request handed from front to back.
    typedef struct packed {
        kind_t       kind;
        logic        neg;
        logic [31:0] word;
        logic        last;
    } req_t;

    function automatic logic [31:0] rev32(input logic [31:0] w);
        rev32 = {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    // Position of the highest set bit; 0 for zero.
    function automatic logic [4:0] msb_pos(input logic [31:0] v);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
            begin
                p = 5'(i);
            end
        end
        msb_pos = p;
    endfunction

endpackage

// ===== rtl/segy_sample_to_ieee_single.sv =====
// Top level of the seismic sample to IEEE-754 single converter.
`timescale 1ns / 1ps
// Usage:
//   Requests enter on start with raw_sample and last_in_trace; one is
//   taken at each clock edge where start is high and busy is low.
//   Results leave on ieee_bits, conv_status and last_out, marked by a
//   one-cycle done strobe; the receiver must take them as they come.
//   Configuration: cfg_we with cfg_index 0 writes sample_format,
//   index 1 writes swap_bytes; write only while no request is in flight.
// Timing:
//   The front end decodes and swaps in the cycle of acceptance and pushes
//   into a two-entry queue; the back end pops the head and registers the
//   result; a request passes a queue entry, then the result register.
//   One request per cycle is sustained as the back end drains one entry
//   every cycle; it never stalls, so busy only rises if the queue is full.
// Reset:
//   rst_n clears the queue and the strobe; sample_format returns to IBM
//   float and swap_bytes to 1.
module segy_sample_to_ieee_single
    import segy_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] raw_sample,
    input  logic        last_in_trace,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [2:0]  cfg_data,
    output logic        done,
    output logic [31:0] ieee_bits,
    output logic [1:0]  conv_status,
    output logic        last_out
);

    logic [2:0] fmt_reg;
    logic       swap_reg;
    req_t       front_req, head;
    logic       push, pop, not_empty, full;

    // Hold configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg  <= FMT_IBM;
            swap_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FORMAT:
                begin
                    fmt_reg <= cfg_data;
                end
                REG_SWAP:
                begin
                    swap_reg <= cfg_data[0];
                end
                default:
                begin
                    fmt_reg <= fmt_reg;
                end
            endcase
        end
    end

    assign busy = full;
    assign push = start && !busy;
    // Drain the queue head every cycle.
    assign pop  = not_empty;

    segy_front u_front (
        .raw_sample    (raw_sample),
        .last_in_trace (last_in_trace),
        .fmt           (fmt_reg),
        .swap          (swap_reg),
        .req           (front_req)
    );

    segy_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_req  (front_req),
        .pop       (pop),
        .not_empty (not_empty),
        .full      (full),
        .head      (head)
    );

    segy_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (pop),
        .req         (head),
        .done        (done),
        .ieee_bits   (ieee_bits),
        .conv_status (conv_status),
        .last_out    (last_out)
    );

`ifndef ASSERT_OFF
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> ##1 done) else $error("request produced no result");
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy) else $error("queue filled with a non-stalling back end");
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(pop)) else $error("result without request");
`endif

endmodule

// ===== rtl/segy_front.sv =====
// Front end: byte swap, format decode and integer magnitude.
`timescale 1ns / 1ps
module segy_front
    import segy_pkg::*;
(
    input  logic [31:0] raw_sample,
    input  logic        last_in_trace,
    input  logic [2:0]  fmt,
    input  logic        swap,
    output req_t        req
);

    logic [31:0] w32;
    logic [15:0] h;

    always_comb
    begin
        w32 = swap ? rev32(raw_sample) : raw_sample;
        h   = swap ? {raw_sample[7:0], raw_sample[15:8]} : raw_sample[15:0];
        req.last = last_in_trace;
        req.neg  = 1'b0;
        req.word = w32;
        req.kind = KIND_ZERO;
        case (fmt)
            FMT_IBM:
            begin
                req.kind = KIND_IBM;
            end
            FMT_INT32:
            begin
                req.kind = KIND_INT;
                req.neg  = w32[31];
                req.word = w32[31] ? (32'd0 - w32) : w32;
            end
            FMT_INT16:
            begin
                req.kind = KIND_INT;
                req.neg  = h[15];
                req.word = {16'd0, h[15] ? (16'd0 - h) : h};
            end
            FMT_IEEE:
            begin
                req.kind = KIND_PASS;
            end
            FMT_INT8:
            begin
                req.kind = KIND_INT;
                req.neg  = raw_sample[7];
                req.word = {24'd0, raw_sample[7] ? (8'd0 - raw_sample[7:0])
                                                 : raw_sample[7:0]};
            end
            default:
            begin
                req.kind = KIND_ZERO;
            end
        endcase
    end

endmodule

// ===== rtl/segy_queue.sv =====
// Short request queue between front and back.
`timescale 1ns / 1ps
module segy_queue
    import segy_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  req_t push_req,
    input  logic pop,
    output logic not_empty,
    output logic full,
    output req_t head
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    req_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [PW:0]   count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign head      = mem_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_req;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty) else $error("queue underflow");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

// ===== rtl/segy_back.sv =====
// Back end: IBM normalize, integer round or IEEE pass-through, result register.
`timescale 1ns / 1ps
module segy_back
    import segy_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  req_t        req,
    output logic        done,
    output logic [31:0] ieee_bits,
    output logic [1:0]  conv_status,
    output logic        last_out
);

    logic [31:0] bits_next, bits_reg;
    logic [1:0]  st_next, st_reg;
    logic        last_reg, done_reg;

    logic [23:0] mant;
    logic [4:0]  lz;
    logic [23:0] nm;
    logic signed [9:0] t;
    logic [4:0]  p;
    logic [4:0]  s;
    logic [31:0] norm;
    logic [24:0] q;
    logic        guard, sticky;
    logic [8:0]  e;

    always_comb
    begin
        bits_next = 32'd0;
        st_next   = ST_OK;
        mant = req.word[23:0];
        lz   = 5'd23 - msb_pos({8'd0, mant});
        nm   = mant << lz;
        t    = 10'(signed'({3'b0, req.word[30:24], 2'b0})) - 10'sd130
               - 10'(signed'({5'b0, lz}));
        p    = msb_pos(req.word);
        s    = 5'd31 - p;
        norm = req.word << s;
        guard  = norm[7];
        sticky = |norm[6:0];
        q = {1'b0, norm[31:8]} + 25'(guard && (sticky || norm[8]));
        e = 9'd127 + 9'(p) + 9'(q[24]);
        case (req.kind)
            KIND_IBM:
            begin
                if (req.word == 32'd0)
                begin
                    bits_next = 32'd0;
                end
                else if (mant == 24'd0)
                begin
                    st_next = ST_ZEROMANT;
                end
                else if (t > 10'sd254)
                begin
                    st_next   = ST_OVERFLOW;
                    bits_next = {req.word[31], MAX_FINITE[30:0]};
                end
                else if (t <= 10'sd0)
                begin
                    st_next = ST_UNDERFLOW;
                end
                else
                begin
                    bits_next = {req.word[31], t[7:0], nm[22:0]};
                end
            end
            KIND_INT:
            begin
                if (req.word != 32'd0)
                begin
                    bits_next = {req.neg, e[7:0],
                                 q[24] ? q[23:1] : q[22:0]};
                end
            end
            KIND_PASS:
            begin
                bits_next = req.word;
            end
            default:
            begin
                bits_next = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            bits_reg <= bits_next;
            st_reg   <= st_next;
            last_reg <= req.last;
        end
    end

    assign done        = done_reg;
    assign ieee_bits   = bits_reg;
    assign conv_status = st_reg;
    assign last_out    = last_reg;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the seismic sample to IEEE-754 single converter.
`timescale 1ns / 1ps
module testbench;
    import segy_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] raw_sample;
    logic        last_in_trace;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [2:0]  cfg_data;
    logic        done;
    logic [31:0] ieee_bits;
    logic [1:0]  conv_status;
    logic        last_out;

    // One converted sample as it should leave the block.
    typedef struct packed {
        logic [31:0] bits;
        logic [1:0]  status;
        logic        last;
    } sample_out_t;

    // Directed row: format, swap, word, last flag, and an optional typed-in answer.
    typedef struct {
        logic [2:0]  fmt;
        logic        swap;
        logic [31:0] word;
        logic        last;
        logic        typed;
        logic [31:0] bits;
        logic [1:0]  status;
    } vector_t;

    sample_out_t pending_q[$];
    logic [2:0]  cur_format;
    logic        cur_swap;
    int          mismatches;
    logic        sender_idle_on;

    segy_sample_to_ieee_single dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .raw_sample    (raw_sample),
        .last_in_trace (last_in_trace),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .ieee_bits     (ieee_bits),
        .conv_status   (conv_status),
        .last_out      (last_out)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Signed integer, given as sign and magnitude, to single bits with
    // round to nearest even.
    function automatic logic [31:0] int_as_single(input logic neg, input logic [31:0] mag);
        int          top;
        int          shift;
        logic [31:0] frac;
        logic [31:0] rem;
        logic [31:0] half;
        logic [8:0]  expo;
        top = 0;
        if (mag == 32'd0)
        begin
            return 32'd0;
        end
        for (int i = 0; i < 32; i++)
        begin
            if (mag[i])
            begin
                top = i;
            end
        end
        expo = 9'(127 + top);
        if (top <= 23)
        begin
            frac = mag << (23 - top);
        end
        else
        begin
            shift = top - 23;
            rem   = mag & ((32'd1 << shift) - 32'd1);
            half  = 32'd1 << (shift - 1);
            frac  = mag >> shift;
            if (rem > half || (rem == half && frac[0]))
            begin
                frac = frac + 32'd1;
            end
            if (frac == 32'h0100_0000)
            begin
                frac = frac >> 1;
                expo = expo + 9'd1;
            end
        end
        return {neg, expo[7:0], frac[22:0]};
    endfunction

    // IBM hex float to single: normalize, then saturate or flush.
    function automatic sample_out_t ibm_as_single(input logic [31:0] w);
        sample_out_t r;
        logic [23:0] mant;
        int          e;
        r = '0;
        if (w == 32'd0)
        begin
            return r;
        end
        mant = w[23:0];
        if (mant == 24'd0)
        begin
            r.status = ST_ZEROMANT;
            return r;
        end
        e = int'(w[30:24]) * 4 - 130;
        while (!mant[23])
        begin
            e--;
            mant = mant << 1;
        end
        if (e > 254)
        begin
            r.bits   = {w[31], MAX_FINITE[30:0]};
            r.status = ST_OVERFLOW;
        end
        else if (e <= 0)
        begin
            r.status = ST_UNDERFLOW;
        end
        else
        begin
            r.bits = {w[31], 8'(e), mant[22:0]};
        end
        return r;
    endfunction

    // Predict the converted sample under the current register settings.
    function automatic sample_out_t convert_sample(input logic [31:0] raw, input logic last);
        sample_out_t r;
        logic [31:0] w;
        logic [15:0] h;
        logic [7:0]  b;
        r = '0;
        w = cur_swap ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
        h = cur_swap ? {raw[7:0], raw[15:8]} : raw[15:0];
        b = raw[7:0];
        case (cur_format)
            FMT_IBM:   r = ibm_as_single(w);
            FMT_INT32: r.bits = int_as_single(w[31], w[31] ? -w : w);
            FMT_INT16: r.bits = int_as_single(h[15], h[15] ? 32'(17'h10000 - h) : 32'(h));
            FMT_IEEE:  r.bits = w;
            FMT_INT8:  r.bits = int_as_single(b[7], b[7] ? 32'(9'h100 - b) : 32'(b));
            default:   r = '0;
        endcase
        r.last = last;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Check every result strobe against the oldest expectation.
    always @(posedge clk)
    begin
        sample_out_t want;
        if (rst_n && done)
        begin
            if (pending_q.size() == 0)
            begin
                report_mismatch("unexpected result", ieee_bits, 32'd0);
            end
            else
            begin
                want = pending_q.pop_front();
                if (ieee_bits !== want.bits)
                begin
                    report_mismatch("ieee_bits", ieee_bits, want.bits);
                end
                if (conv_status !== want.status)
                begin
                    report_mismatch("conv_status", 32'(conv_status), 32'(want.status));
                end
                if (last_out !== want.last)
                begin
                    report_mismatch("last_out", 32'(last_out), 32'(want.last));
                end
            end
        end
    end

    // Write one register; call only while nothing is in flight. The caller
    // drops cfg_we once its last write is done.
    task automatic write_reg(input logic [0:0] idx, input logic [2:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == REG_FORMAT)
        begin
            cur_format = val;
        end
        else
        begin
            cur_swap = val[0];
        end
    endtask

    // Drop start, wait for all expected results, then let the pipeline settle.
    task automatic drain_pipeline();
        start <= 1'b0;
        while (pending_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Present one request and hold it until accepted; queue its prediction.
    // start stays high afterwards so requests can follow back to back.
    task automatic send_sample(input logic [31:0] word, input logic last, input logic typed,
                               input sample_out_t given);
        sample_out_t want;
        if (sender_idle_on && $urandom_range(0, 7) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        start         <= 1'b1;
        raw_sample    <= word;
        last_in_trace <= last;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        want = typed ? given : convert_sample(word, last);
        pending_q.push_back(want);
    endtask

    // Random word biased toward what each format finds interesting.
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 9))
            0: w = w & 32'hff00_0000;
            1: w = w | 32'h00ff_ffff;
            2: w[23:0] = 24'(1) << $urandom_range(0, 23);
            3: w[15:0] = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            4: w = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            5: w[7:0] = $urandom_range(0, 1) ? 8'h80 : 8'h7f;
            default: ;
        endcase
        return w;
    endfunction

    vector_t directed[$];

    task automatic add_row(input logic [2:0] f, input logic s, input logic [31:0] w,
                           input logic t, input logic [31:0] b, input logic [1:0] st);
        vector_t v;
        v = '{f, s, w, w[0], t, b, st};
        directed.push_back(v);
    endtask

    initial
    begin
        sample_out_t given;
        int          total;
        mismatches     = 0;
        sender_idle_on = 1'b0;
        cur_format     = FMT_IBM;
        cur_swap       = 1'b1;
        start          = 1'b0;
        raw_sample     = '0;
        last_in_trace  = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_FORMAT;
        cfg_data       = '0;
        rst_n          = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset: IBM with swap; zero word, and swapped +1.0 (0x41100000).
        add_row(FMT_IBM,   1, 32'h0000_0000, 1, 32'h0000_0000, ST_OK);
        add_row(FMT_IBM,   1, 32'h0000_1041, 0, 32'h3f80_0000, ST_OK);
        add_row(FMT_IBM,   0, 32'h4100_0000, 1, 32'h0000_0000, ST_ZEROMANT);
        add_row(FMT_IBM,   0, 32'h7fff_ffff, 1, 32'h7f7f_ffff, ST_OVERFLOW);
        add_row(FMT_IBM,   0, 32'hffff_ffff, 0, 32'hff7f_ffff, ST_OVERFLOW);
        add_row(FMT_IBM,   0, 32'h8000_0001, 0, 32'h0000_0000, ST_UNDERFLOW);
        add_row(FMT_IBM,   0, 32'hc276_a000, 0, 32'h0, ST_OK);
        add_row(FMT_IBM,   0, 32'h2100_0001, 1, 32'h0, ST_OK);
        add_row(FMT_INT32, 0, 32'h8000_0000, 1, 32'hcf00_0000, ST_OK);
        add_row(FMT_INT32, 0, 32'h7fff_ffff, 0, 32'h4f00_0000, ST_OK);
        add_row(FMT_INT32, 0, 32'h0100_0001, 1, 32'h0, ST_OK);
        add_row(FMT_INT32, 1, 32'h0300_0001, 0, 32'h0, ST_OK);
        add_row(FMT_INT16, 0, 32'hffff_8000, 1, 32'hc700_0000, ST_OK);
        add_row(FMT_INT16, 1, 32'h1234_ff7f, 0, 32'h0, ST_OK);
        add_row(FMT_IEEE,  0, 32'h7fc0_0001, 1, 32'h7fc0_0001, ST_OK);
        add_row(FMT_IEEE,  1, 32'h0000_807f, 0, 32'h7f80_0000, ST_OK);
        add_row(FMT_INT8,  1, 32'hffff_ff80, 1, 32'hc300_0000, ST_OK);
        add_row(FMT_INT8,  0, 32'h0000_007f, 0, 32'h0, ST_OK);
        add_row(3'd5,      0, 32'hdead_beef, 1, 32'h0000_0000, ST_OK);
        add_row(3'd7,      1, 32'hffff_ffff, 0, 32'h0000_0000, ST_OK);

        foreach (directed[i])
        begin
            if (directed[i].fmt != cur_format || directed[i].swap != cur_swap)
            begin
                drain_pipeline();
                write_reg(REG_FORMAT, directed[i].fmt);
                write_reg(REG_SWAP, 3'(directed[i].swap));
                cfg_we <= 1'b0;
            end
            given = '{directed[i].bits, directed[i].status, directed[i].last};
            send_sample(directed[i].word, directed[i].last,
                        directed[i].typed && directed[i].bits != 32'h0
                        || directed[i].typed && directed[i].status != ST_OK
                        || directed[i].typed && directed[i].word == 32'h0
                        || directed[i].typed && directed[i].fmt > FMT_INT8,
                        given);
        end

        // Random phases: new settings each phase, random idling, then a
        // final stretch at full rate.
        sender_idle_on = 1'b1;
        total = 0;
        while (total < 1450)
        begin
            drain_pipeline();
            write_reg(REG_FORMAT, ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                               : 3'($urandom_range(0, 4)));
            write_reg(REG_SWAP, 3'($urandom_range(0, 1)));
            cfg_we <= 1'b0;
            if (total > 1200)
            begin
                sender_idle_on = 1'b0;
            end
            repeat ($urandom_range(20, 90))
            begin
                send_sample(pick_word(), 1'($urandom_range(0, 1)), 1'b0, '0);
                total++;
            end
            // While fewer than 300 samples are sent, hold off until every expected result is back.
            if (total < 300)
            begin
                start <= 1'b0;
                while (pending_q.size() != 0)
                begin
                    @(posedge clk);
                end
            end
        end

        drain_pipeline();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/segy_pkg.sv
rtl/segy_front.sv
rtl/segy_queue.sv
rtl/segy_back.sv
rtl/segy_sample_to_ieee_single.sv
sim/testbench.sv
